FILE: rtl/rgb_to_hsl_converter_top_macros.svh
// Assertion macros shared by the converter's checker.
`ifndef RGB_TO_HSL_CONVERTER_TOP_MACROS_SVH
`define RGB_TO_HSL_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGBHSL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rgb to hsl converter check failed");

// Implication with a fixed delay in cycles.
`define RGBHSL_ASSERT_DELAY(lbl, clk, rstn, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##(n) (cons)) \
        else $error("rgb to hsl converter latency check failed");

`endif

FILE: rtl/rgbhsl_pkg.sv
// Shared types and constants of the RGB to HSL converter.
package rgbhsl_pkg;

    // Register stages ahead of the divider steps: clamp, min/max, scale, setup.
    localparam int FRONT_STAGES = 4;

    // Which channel holds the maximum; red is tested first, then green.
    typedef enum logic [1:0]
    {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

endpackage

FILE: rtl/rgb_to_hsl_converter_top.sv
// RGB to HSL converter: clamp, min/max, and two pipelined restoring dividers.
//
// Usage:
//   One colour beat (red, green, blue, unsigned, 1.0 = 2^FRAC_BITS) enters at
//   a rising edge where start is high and busy is low. busy is always low:
//   a new beat may enter on every clock cycle.
//   The result beat (hue, saturation, lightness) appears on its ports for
//   exactly one cycle with done high, once the beat has passed the clamp,
//   min/max, scaling and setup registers and every divider stage.
//   Throughput is one beat per cycle. The pipeline is four front stages (clamp,
//   min/max, scaling, divider setup) plus FRAC_BITS + 1 divider stages, one
//   quotient bit per stage, for saturation and hue side by side.
//   The receiver cannot stall; nothing inside the block waits on it.
//   Reset clears the valid bits of every stage, so no stale beat comes out;
//   the data registers are not reset.
module rgb_to_hsl_converter_top #(
    parameter int FRAC_BITS = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    output logic        done,
    output logic [14:0] hue,
    output logic [15:0] saturation,
    output logic [15:0] lightness
);

    localparam int VW = FRAC_BITS + 1;
    localparam int SW = VW + 1;
    localparam int DW = VW + 3;
    localparam int QW = FRAC_BITS + 1;
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;
    localparam logic [SW-1:0] TWO_ONE = SW'(ONE << 1);

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [DW:0] div_step(
        input logic [DW-1:0] rem,
        input logic          bit_in,
        input logic [DW-1:0] den
    );
        logic [DW+1:0] trial;
        logic [DW:0]   shifted;
        shifted = {rem, bit_in};
        trial   = {1'b0, shifted} - {2'b00, den};
        if (!trial[DW+1])
        begin
            div_step = {1'b1, trial[DW-1:0]};
        end
        else
        begin
            div_step = {1'b0, shifted[DW-1:0]};
        end
    endfunction

    // Stage A: clamped inputs.
    logic                 a_valid_reg;
    logic [VW-1:0]        a_r_reg, a_g_reg, a_b_reg;
    logic [VW-1:0]        a_r_next, a_g_next, a_b_next;

    // Stage B: extremes and difference.
    logic                 b_valid_reg;
    logic [VW-1:0]        b_d_reg, b_d_next;
    logic [SW-1:0]        b_sum_reg, b_sum_next;
    logic signed [VW:0]   b_diff_reg, b_diff_next;
    rgbhsl_pkg::max_sel_t b_sel_reg, b_sel_next;
    logic                 b_grey_reg;
    logic [VW-1:0]        b_mx, b_mn, b_rg_max, b_rg_min;

    // Stage C: scaled terms and saturation divisor.
    logic                 c_valid_reg;
    logic [VW-1:0]        c_d_reg;
    logic [DW-1:0]        c_kd_reg, c_kd_next;
    logic [DW-1:0]        c_six_d_reg, c_six_d_next;
    logic [SW-1:0]        c_den_reg, c_den_next;
    logic signed [VW:0]   c_diff_reg;
    logic [VW-1:0]        c_light_reg;
    logic                 c_grey_reg;

    // Divider pipeline; index 0 is the setup stage.
    logic                 dv_valid_reg [QW+1];
    logic                 dv_grey_reg  [QW+1];
    logic [VW-1:0]        dv_light_reg [QW+1];
    logic [DW-1:0]        s_rem_reg    [QW+1];
    logic [DW-1:0]        s_den_reg    [QW+1];
    logic [QW-1:0]        s_q_reg      [QW+1];
    logic [DW-1:0]        h_rem_reg    [QW+1];
    logic [DW-1:0]        h_den_reg    [QW+1];
    logic [QW-1:0]        h_q_reg      [QW+1];
    logic                 s_lsb_reg, h_lsb_reg;
    logic [DW-1:0]        d_num_next;

    assign busy = 1'b0;

    // Stage A.
    always_comb
    begin
        a_r_next = (32'(red) > ONE)   ? ONE[VW-1:0] : VW'(red);
        a_g_next = (32'(green) > ONE) ? ONE[VW-1:0] : VW'(green);
        a_b_next = (32'(blue) > ONE)  ? ONE[VW-1:0] : VW'(blue);
    end

    // Stage B.
    always_comb
    begin
        b_rg_max   = (a_r_reg > a_g_reg) ? a_r_reg : a_g_reg;
        b_rg_min   = (a_r_reg < a_g_reg) ? a_r_reg : a_g_reg;
        b_mx       = (b_rg_max > a_b_reg) ? b_rg_max : a_b_reg;
        b_mn       = (b_rg_min < a_b_reg) ? b_rg_min : a_b_reg;
        b_d_next   = b_mx - b_mn;
        b_sum_next = SW'(b_mx) + SW'(b_mn);
        if (a_r_reg == b_mx)
        begin
            b_sel_next  = rgbhsl_pkg::MAX_RED;
            b_diff_next = $signed({1'b0, a_g_reg}) - $signed({1'b0, a_b_reg});
        end
        else if (a_g_reg == b_mx)
        begin
            b_sel_next  = rgbhsl_pkg::MAX_GREEN;
            b_diff_next = $signed({1'b0, a_b_reg}) - $signed({1'b0, a_r_reg});
        end
        else
        begin
            b_sel_next  = rgbhsl_pkg::MAX_BLUE;
            b_diff_next = $signed({1'b0, a_r_reg}) - $signed({1'b0, a_g_reg});
        end
    end

    // Stage C.
    always_comb
    begin
        c_six_d_next = (DW'(b_d_reg) << 2) + (DW'(b_d_reg) << 1);
        unique case (b_sel_reg)
            rgbhsl_pkg::MAX_RED:   c_kd_next = DW'(b_d_reg) << 1;
            rgbhsl_pkg::MAX_GREEN: c_kd_next = DW'(b_d_reg) << 2;
            rgbhsl_pkg::MAX_BLUE:  c_kd_next = c_six_d_next;
            default:               c_kd_next = c_six_d_next;
        endcase
        // Dark half divides by the sum, bright half by two minus the sum.
        c_den_next = (32'(b_sum_reg) <= ONE) ? b_sum_reg : TWO_ONE - b_sum_reg;
    end

    // Stage D: hue numerator; the true value is positive and fits DW bits.
    assign d_num_next = c_kd_reg + {{(DW-VW-1){c_diff_reg[VW]}}, c_diff_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            c_valid_reg     <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            a_valid_reg     <= start && !busy;
            b_valid_reg     <= a_valid_reg;
            c_valid_reg     <= b_valid_reg;
            dv_valid_reg[0] <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_r_reg <= a_r_next;
        a_g_reg <= a_g_next;
        a_b_reg <= a_b_next;

        b_d_reg    <= b_d_next;
        b_sum_reg  <= b_sum_next;
        b_diff_reg <= b_diff_next;
        b_sel_reg  <= b_sel_next;
        b_grey_reg <= (b_d_next == '0);

        c_d_reg     <= b_d_reg;
        c_kd_reg    <= c_kd_next;
        c_six_d_reg <= c_six_d_next;
        c_den_reg   <= c_den_next;
        c_diff_reg  <= b_diff_reg;
        c_light_reg <= b_sum_reg[SW-1:1];
        c_grey_reg  <= b_grey_reg;

        // The dividend is x * 2^FRAC_BITS: its top part x / 2 seeds the
        // remainder, x's low bit enters on the first step, zeros after.
        dv_grey_reg[0]  <= c_grey_reg;
        dv_light_reg[0] <= c_light_reg;
        s_rem_reg[0]    <= DW'(c_d_reg[VW-1:1]);
        s_lsb_reg       <= c_d_reg[0];
        s_den_reg[0]    <= DW'(c_den_reg);
        s_q_reg[0]      <= '0;
        h_rem_reg[0]    <= d_num_next >> 1;
        h_lsb_reg       <= d_num_next[0];
        h_den_reg[0]    <= c_six_d_reg;
        h_q_reg[0]      <= '0;
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        logic          s_bit_in, h_bit_in;
        logic [DW:0]   s_step_next, h_step_next;

        if (i == 0)
        begin : g_first
            assign s_bit_in = s_lsb_reg;
            assign h_bit_in = h_lsb_reg;
        end
        else
        begin : g_rest
            assign s_bit_in = 1'b0;
            assign h_bit_in = 1'b0;
        end

        assign s_step_next = div_step(s_rem_reg[i], s_bit_in, s_den_reg[i]);
        assign h_step_next = div_step(h_rem_reg[i], h_bit_in, h_den_reg[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_grey_reg[i+1]  <= dv_grey_reg[i];
            dv_light_reg[i+1] <= dv_light_reg[i];
            s_den_reg[i+1]    <= s_den_reg[i];
            s_rem_reg[i+1]    <= s_step_next[DW-1:0];
            s_q_reg[i+1]      <= {s_q_reg[i][QW-2:0], s_step_next[DW]};
            h_den_reg[i+1]    <= h_den_reg[i];
            h_rem_reg[i+1]    <= h_step_next[DW-1:0];
            h_q_reg[i+1]      <= {h_q_reg[i][QW-2:0], h_step_next[DW]};
        end
    end

    // Hue wraps modulo one by dropping the integer bit of its quotient.
    assign done       = dv_valid_reg[QW];
    assign hue        = dv_grey_reg[QW] ? '0 : 15'(h_q_reg[QW][FRAC_BITS-1:0]);
    assign saturation = dv_grey_reg[QW] ? '0 : 16'(s_q_reg[QW]);
    assign lightness  = 16'(dv_light_reg[QW]);

endmodule

FILE: rtl/rgbhsl_checker.sv
// Port-level checks of the RGB to HSL converter, bound to its top level.
`include "rgb_to_hsl_converter_top_macros.svh"

module rgbhsl_checker #(
    parameter int FRAC_BITS = 15
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [15:0] red,
    input logic [15:0] green,
    input logic [15:0] blue,
    input logic        done,
    input logic [14:0] hue,
    input logic [15:0] saturation,
    input logic [15:0] lightness
);

    localparam int LAT = rgbhsl_pkg::FRONT_STAGES + FRAC_BITS + 1;
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    // Every accepted beat comes out after exactly the pipeline latency.
    `RGBHSL_ASSERT_DELAY(a_beat_out, clk, rst_n, start && !busy, LAT, done)

    // No result beat appears without a beat accepted that long ago.
    `RGBHSL_ASSERT_IMPL(a_no_phantom, clk, rst_n, done, $past(start && !busy, LAT))

    // Zero saturation only happens for grey, where hue is zero too.
    `RGBHSL_ASSERT_IMPL(a_grey_hue, clk, rst_n, done && saturation == '0, hue == '0)

    // Saturation and lightness never exceed one.
    `RGBHSL_ASSERT_IMPL(a_range, clk, rst_n, done, (32'(saturation) <= ONE) && (32'(lightness) <= ONE))

endmodule

bind rgb_to_hsl_converter_top rgbhsl_checker #(.FRAC_BITS(FRAC_BITS)) u_rgbhsl_checker (.*);

FILE: test/tb.sv
// Self-checking testbench for the RGB to HSL converter top level.
`timescale 1ns / 100ps

module tb;

    localparam int FRAC = 15;
    localparam longint ONE = longint'(1) << FRAC;
    localparam int LATENCY = FRAC + 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 134;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] sat;
        logic [15:0] light;
    } hsl_t;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic        typed;
        hsl_t        want;
    } color_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [15:0] red = '0;
    logic [15:0] green = '0;
    logic [15:0] blue = '0;
    logic        busy;
    logic        done;
    logic [14:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;

    hsl_t       pending_hsl[$];
    color_row_t color_table[$];

    int cycle_count = 0;
    int n_errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_clamped = 0;
    int n_grey = 0;
    int n_light_half = 0;

    rgb_to_hsl_converter_top #(
        .FRAC_BITS(FRAC)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .red(red),
        .green(green),
        .blue(blue),
        .done(done),
        .hue(hue),
        .saturation(saturation),
        .lightness(lightness)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_hsl.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Predicts hue, saturation and lightness of one colour beat.
    function automatic hsl_t rgb_to_hsl(input logic [15:0] r_raw, input logic [15:0] g_raw,
                                        input logic [15:0] b_raw);
        longint               r, g, b, mx, mn, d, sum, k, diff, num, sat, hue_frac;
        rgbhsl_pkg::max_sel_t sel;
        hsl_t                 res;
        r = (r_raw > ONE) ? ONE : longint'(r_raw);
        g = (g_raw > ONE) ? ONE : longint'(g_raw);
        b = (b_raw > ONE) ? ONE : longint'(b_raw);
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        d = mx - mn;
        sum = mx + mn;
        res.light = 16'((sum >> 1) & 64'hFFFF);
        res.sat = '0;
        res.hue = '0;
        if (d != 0)
        begin
            if (sum <= ONE)
                sat = (d * ONE) / sum;
            else
                sat = (d * ONE) / (2 * ONE - sum);
            res.sat = 16'(sat & 64'hFFFF);
            // Red wins a tie for the maximum, then green.
            if (r == mx)
                sel = rgbhsl_pkg::MAX_RED;
            else if (g == mx)
                sel = rgbhsl_pkg::MAX_GREEN;
            else
                sel = rgbhsl_pkg::MAX_BLUE;
            case (sel)
                rgbhsl_pkg::MAX_RED:
                begin
                    k = 2;
                    diff = g - b;
                end
                rgbhsl_pkg::MAX_GREEN:
                begin
                    k = 4;
                    diff = b - r;
                end
                default:
                begin
                    k = 6;
                    diff = r - g;
                end
            endcase
            num = k * d + diff;
            // Hue of a full turn or more wraps to its fractional part.
            hue_frac = ((num * ONE) / (6 * d)) & (ONE - 1);
            res.hue = 15'(hue_frac & 64'h7FFF);
        end
        return res;
    endfunction

    task automatic add_row(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                           input logic typed, input logic [14:0] h, input logic [15:0] s,
                           input logic [15:0] l);
        color_row_t row;
        row.r = r;
        row.g = g;
        row.b = b;
        row.typed = typed;
        row.want.hue = h;
        row.want.sat = s;
        row.want.light = l;
        color_table.push_back(row);
    endtask

    // Drives one colour beat and records its expected result once it is taken.
    task automatic send_color(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b,
                              input hsl_t want);
        start <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_hsl.push_back(want);
        n_sent++;
        if (r > ONE || g > ONE || b > ONE)
            n_clamped++;
        if (want.sat == 0)
            n_grey++;
        if (want.light > (ONE >> 1))
            n_light_half++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_hsl.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_channel();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'd0;
            1: v = 16'(ONE);
            2: v = 16'($urandom_range(0, 65535));
            3: v = 16'($urandom_range(32700, 32768));
            4: v = 16'($urandom_range(0, 64));
            default: v = 16'($urandom_range(0, 32768));
        endcase
        return v;
    endfunction

    always @(posedge clk)
    begin
        hsl_t want;
        if (rst_n && done)
        begin
            if (pending_hsl.size() == 0)
            begin
                if (n_errors < MAX_REPORTS)
                    $display("unexpected result beat: hue=%0d sat=%0d light=%0d",
                             hue, saturation, lightness);
                n_errors++;
            end
            else
            begin
                want = pending_hsl.pop_front();
                n_checked++;
                if (hue !== want.hue || saturation !== want.sat || lightness !== want.light)
                begin
                    if (n_errors < MAX_REPORTS)
                        $display("result %0d: expected hue=%0d sat=%0d light=%0d,",
                                 n_checked, want.hue, want.sat, want.light,
                                 " got hue=%0d sat=%0d light=%0d",
                                 hue, saturation, lightness);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        logic [15:0] r, g, b;
        int          idle_pct;
        hsl_t        want;

        // Typed rows: dark and white, clamping, primaries; blue hue wraps to zero.
        add_row(16'd0, 16'd0, 16'd0, 1'b1, 15'd0, 16'd0, 16'd0);
        add_row(16'd32768, 16'd32768, 16'd32768, 1'b1, 15'd0, 16'd0, 16'd32768);
        add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 15'd0, 16'd0, 16'd32768);
        add_row(16'd32768, 16'd0, 16'd0, 1'b1, 15'd10922, 16'd32768, 16'd16384);
        add_row(16'd0, 16'd32768, 16'd0, 1'b1, 15'd21845, 16'd32768, 16'd16384);
        add_row(16'd0, 16'd0, 16'd32768, 1'b1, 15'd0, 16'd32768, 16'd16384);
        add_row(16'hFFFF, 16'd0, 16'd0, 1'b1, 15'd10922, 16'd32768, 16'd16384);
        add_row(16'd12345, 16'd12345, 16'd12345, 1'b1, 15'd0, 16'd0, 16'd12345);
        // Predicted rows: ties, negative differences, bright colours, hue past a turn.
        add_row(16'd32768, 16'd0, 16'd16384, 1'b0, '0, '0, '0);
        add_row(16'd32768, 16'd32768, 16'd0, 1'b0, '0, '0, '0);
        add_row(16'd0, 16'd32768, 16'd32768, 1'b0, '0, '0, '0);
        add_row(16'd16384, 16'd0, 16'd32768, 1'b0, '0, '0, '0);
        add_row(16'd32768, 16'd16384, 16'd0, 1'b0, '0, '0, '0);
        add_row(16'd0, 16'd16384, 16'd32768, 1'b0, '0, '0, '0);
        add_row(16'd32768, 16'd32767, 16'd32767, 1'b0, '0, '0, '0);
        add_row(16'd32000, 16'd30000, 16'd20000, 1'b0, '0, '0, '0);
        add_row(16'd1, 16'd0, 16'd0, 1'b0, '0, '0, '0);
        add_row(16'd1, 16'd2, 16'd3, 1'b0, '0, '0, '0);
        add_row(16'h7FFF, 16'h5555, 16'h2AAA, 1'b0, '0, '0, '0);
        add_row(16'h2AAA, 16'h5555, 16'h7FFF, 1'b0, '0, '0, '0);
        add_row(16'h8000, 16'h7FFF, 16'h0000, 1'b0, '0, '0, '0);
        add_row(16'h4000, 16'h4001, 16'h3FFF, 1'b0, '0, '0, '0);
        add_row(16'd1, 16'd1, 16'd0, 1'b0, '0, '0, '0);
        add_row(16'h8001, 16'hC000, 16'd100, 1'b0, '0, '0, '0);

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (color_table[i])
        begin
            want = color_table[i].typed ? color_table[i].want
                 : rgb_to_hsl(color_table[i].r, color_table[i].g, color_table[i].b);
            send_color(color_table[i].r, color_table[i].g, color_table[i].b, want);
        end
        drain_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 29 : (phase == 1) ? 67 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = pick_channel();
                g = pick_channel();
                b = pick_channel();
                // Force ties and greys now and then so the tie order is exercised.
                case ($urandom_range(0, 19))
                    0: g = r;
                    1: b = g;
                    2:
                    begin
                        g = r;
                        b = r;
                    end
                    default: ;
                endcase
                send_color(r, g, b, rgb_to_hsl(r, g, b));
                if (phase == 0 && n == ITEMS_PER_PHASE / 2)
                    drain_results();
                else
                begin
                    // Each cycle the sender stays idle with the phase's probability.
                    while ($urandom_range(0, 99) < idle_pct)
                    begin
                        start <= 1'b0;
                        @(posedge clk);
                    end
                end
            end
            drain_results();
        end

        start <= 1'b0;
        while (pending_hsl.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY)
            @(posedge clk);

        $display("Converted %0d colors (%0d clamped, %0d grey, %0d above half lightness).",
                 n_sent, n_clamped, n_grey, n_light_half);
        $display("Checked %0d result beats, %0d failures.", n_checked, n_errors);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
